>>> src/slid_pkg.sv
// Shared constants, codes and types for the sorted list insert/delete block.
// No dependencies; every other file in src/ refers to this package by scoped names.
package slid_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VAL_W        = 32;
  localparam int STATUS_W     = 3;
  localparam int COUNT_W      = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp_en;  // register compare flags against the held word
    logic ins_en;  // apply an insert shift
    logic del_en;  // apply a delete shift
  } cell_ctrl_t;

endpackage

>>> src/sorted_list_insert_delete_core.sv
// Sorted bounded list: a word passes the compare state and the shift state of the cell row,
// then out_valid shows its result; the next word can be taken in the shift state. The receiver
// cannot stall. rst_n is synchronous and active low; it empties the list and clears the
// sequencer and strobe. Stored entries are not cleared.
module sorted_list_insert_delete_core #(
  parameter int CAPACITY = slid_pkg::CAPACITY_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_opcode,
  input  logic signed [slid_pkg::VAL_W-1:0]      in_value,
  output logic                                   out_valid,
  output logic [slid_pkg::STATUS_W-1:0]          out_status,
  output logic [slid_pkg::COUNT_W-1:0]           out_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  // Sequencer state and the word being worked on.
  state_t                            state_r, state_nxt;
  slid_pkg::op_t                     op_r;
  logic signed [slid_pkg::VAL_W-1:0] val_r;
  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;
  logic                              out_valid_r, out_valid_nxt;
  slid_pkg::status_t                 status_r, status_nxt;

  logic                              accept;
  logic                              full;
  logic                              found;
  slid_pkg::cell_ctrl_t              ctrl;

  // Neighbour links along the row of cells.
  logic signed [slid_pkg::VAL_W-1:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0]               gt_w;
  logic [CAPACITY-1:0]               seen_w;

  // The row is only busy while it compares; during the shift cycle the next word can be
  // taken, because its compare happens after the shift has landed.
  assign busy   = (state_r == S_CMP);
  assign accept = start && !busy;
  assign full   = (cnt_r == CNT_W'(CAPACITY));
  assign found  = seen_w[CAPACITY-1];

  always_comb begin
    ctrl        = '0;
    ctrl.cmp_en = (state_r == S_CMP);
    if (state_r == S_UPD) begin
      ctrl.ins_en = (op_r == slid_pkg::OP_INSERT) && !full;
      ctrl.del_en = (op_r == slid_pkg::OP_DELETE);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        state_nxt     = accept ? S_CMP : S_IDLE;
        out_valid_nxt = 1'b1;
        if (op_r == slid_pkg::OP_INSERT) begin
          if (full) begin
            status_nxt = slid_pkg::ST_FULL;
          end else begin
            status_nxt = slid_pkg::ST_INSERTED;
            cnt_nxt    = cnt_r + CNT_W'(1);
          end
        end else if (cnt_r == '0) begin
          status_nxt = slid_pkg::ST_EMPTY;
        end else if (found) begin
          status_nxt = slid_pkg::ST_DELETED;
          cnt_nxt    = cnt_r - CNT_W'(1);
        end else begin
          status_nxt = slid_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      status_r    <= slid_pkg::ST_INSERTED;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
    if (accept) begin
      op_r  <= slid_pkg::op_t'(in_opcode);
      val_r <= in_value;
    end
  end

  // Each cell compares its entry with the held word in the compare cycle. In the shift cycle
  // an insert moves the larger entries one place right and drops the word into the first
  // larger place; a delete pulls every entry from the first match onwards one place left.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [slid_pkg::VAL_W-1:0] left_e, right_e;
    logic                              left_g, left_s;
    if (i == 0) begin : g_first
      assign left_e = entry_w[i];
      assign left_g = 1'b0;
      assign left_s = 1'b0;
    end else begin : g_mid
      assign left_e = entry_w[i-1];
      assign left_g = gt_w[i-1];
      assign left_s = seen_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_e = entry_w[i];
    end else begin : g_inner
      assign right_e = entry_w[i+1];
    end
    slid_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (cnt_r > CNT_W'(i)),
      .key         (val_r),
      .left_entry  (left_e),
      .left_gt     (left_g),
      .right_entry (right_e),
      .left_seen   (left_s),
      .entry       (entry_w[i]),
      .gt          (gt_w[i]),
      .seen        (seen_w[i])
    );
  end

  // The count port shows the entry count reduced to its low five bits.
  logic [CNT_W+slid_pkg::COUNT_W-1:0] cnt_ext;
  assign cnt_ext    = {{slid_pkg::COUNT_W{1'b0}}, cnt_r};
  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_count  = cnt_ext[slid_pkg::COUNT_W-1:0];

endmodule

>>> src/slid_cell.sv
// One storage cell of the sorted list: holds a single entry and its compare flags.
// Depends on slid_pkg for the control struct and the value width.
module slid_cell (
  input  logic                                clk,
  input  slid_pkg::cell_ctrl_t                ctrl,
  input  logic                                occupied,
  input  logic signed [slid_pkg::VAL_W-1:0]   key,
  input  logic signed [slid_pkg::VAL_W-1:0]   left_entry,
  input  logic                                left_gt,
  input  logic signed [slid_pkg::VAL_W-1:0]   right_entry,
  input  logic                                left_seen,
  output logic signed [slid_pkg::VAL_W-1:0]   entry,
  output logic                                gt,
  output logic                                seen
);

  logic signed [slid_pkg::VAL_W-1:0] entry_r;
  logic signed [slid_pkg::VAL_W-1:0] entry_nxt;
  logic                              gt_r;
  logic                              eq_r;

  // A free cell counts as larger than any key, so the flags form a step.
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      gt_r <= !occupied || (entry_r > key);
      eq_r <= occupied && (entry_r == key);
    end
    entry_r <= entry_nxt;
  end

  assign seen = left_seen | eq_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins_en && gt_r) begin
      entry_nxt = left_gt ? left_entry : key;
    end else if (ctrl.del_en && seen) begin
      entry_nxt = right_entry;
    end
  end

  assign entry = entry_r;
  assign gt    = gt_r;

endmodule

>>> src/slid_checker.sv
// Port-level checks for the sorted list core, attached to it by the bind at the end.
// Depends on slid_pkg for the status codes.
module slid_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic [slid_pkg::STATUS_W-1:0]     out_status,
  input logic [slid_pkg::COUNT_W-1:0]      out_count
);

  // Every accepted word gets its result after its compare and shift states.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##3 out_valid)
    else $error("accepted word produced no result");

  // The row is busy for one compare cycle only.
  a_busy_short: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held beyond the compare cycle");

  // Results never come on adjacent cycles.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results on adjacent cycles");

  // An empty report leaves no entries.
  a_count_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == slid_pkg::ST_EMPTY) |-> out_count == '0)
    else $error("empty status with non-zero count");

  a_status_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == slid_pkg::ST_INSERTED) || (out_status == slid_pkg::ST_FULL)
      || (out_status == slid_pkg::ST_DELETED) || (out_status == slid_pkg::ST_NOT_FOUND)
      || (out_status == slid_pkg::ST_EMPTY))
    else $error("undefined status code");

endmodule

bind sorted_list_insert_delete_core slid_checker u_slid_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_status (out_status),
  .out_count  (out_count)
);
